// ===== hdl/bptc_pkg.sv =====
// Package for the barometer compensation pipeline: base constants, shift amounts, register indexes.
package bptc_pkg;

  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_CALIB_A = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CALIB_B = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CALIB_C = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CALIB_D = 2'd3;

  localparam logic [16:0]        UT1_BASE  = 17'd20224;
  localparam logic signed [16:0] D1_BASE   = 17'sd7168;
  localparam logic signed [10:0] C4_BASE   = 11'sd512;
  localparam logic [6:0]         C6_BASE   = 7'd50;
  localparam logic signed [18:0] SENS_BASE = 19'sd24576;
  localparam logic signed [23:0] TEMP_BASE = 24'sd204800;
  localparam logic signed [20:0] PRES_BASE = 21'sd8000;

  localparam int unsigned OFF_SHIFT  = 12;
  localparam int unsigned SENS_SHIFT = 10;
  localparam int unsigned X_SHIFT    = 14;

endpackage

// ===== hdl/baro_pressure_temp_compensation.sv =====
// Five-stage pipeline applying barometer pressure/temperature compensation.
//
//  channel  direction  handshake           payload
//  in_      request    in_valid/in_stall   in_pressure_raw, in_temperature_raw
//  out_     result     out_valid/out_stall out_pressure_q5, out_temperature_q10
//  cfg_     write      cfg_we              cfg_idx, cfg_wdata
//
// One request per cycle while in_stall is low; each result passes through five register
// stages (dT, dT products, OFF/SENS, SENS*(D1-7168), pressure), the first loaded at acceptance.
// Stages advance independently, so bubbles collapse under out_stall.
// in_stall rises only when all five stages hold data and out_stall is high.
// Synchronous reset clears the stage valid bits and the calibration words.
module baro_pressure_temp_compensation
  import bptc_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [15:0]                  in_pressure_raw,
  input  logic [15:0]                  in_temperature_raw,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [20:0]           out_pressure_q5,
  output logic signed [23:0]           out_temperature_q10,
  input  logic                         cfg_we,
  input  logic [CFG_IDX_W-1:0]         cfg_idx,
  input  logic [CFG_DATA_W-1:0]        cfg_wdata
);

  logic [15:0] wa_r, wb_r, wc_r, wd_r;

  logic [14:0] c1;
  logic [11:0] c2;
  logic [9:0]  c3, c4;
  logic [10:0] c5;
  logic [5:0]  c6;

  assign c1 = wa_r[15:1];
  assign c5 = {wa_r[0], wb_r[15:6]};
  assign c6 = wb_r[5:0];
  assign c4 = wc_r[15:6];
  assign c2 = {wc_r[5:0], wd_r[5:0]};
  assign c3 = wd_r[15:6];

  logic v1_r, v2_r, v3_r, v4_r, v5_r;
  logic rdy1, rdy2, rdy3, rdy4, rdy5;

  assign rdy5 = !v5_r || !out_stall;
  assign rdy4 = !v4_r || rdy5;
  assign rdy3 = !v3_r || rdy4;
  assign rdy2 = !v2_r || rdy3;
  assign rdy1 = !v1_r || rdy2;
  assign in_stall = !rdy1;

  // stage 1: dT and D1 offset
  logic [16:0]        ut1;
  logic signed [17:0] dt_nxt, dt_r;
  logic signed [16:0] d1m_nxt, d1m_r;

  assign ut1     = {3'b000, c5, 3'b000} + UT1_BASE;
  assign dt_nxt  = $signed({2'b00, in_temperature_raw}) - $signed({1'b0, ut1});
  assign d1m_nxt = $signed({1'b0, in_pressure_raw}) - D1_BASE;

  // stage 2: dT products
  logic signed [10:0] c4m, c3s;
  logic [6:0]         c6p;
  logic signed [28:0] pc4_nxt, pc4_r, pc3_nxt, pc3_r;
  logic signed [25:0] pt_nxt, pt_r;
  logic signed [16:0] d1m2_r;

  assign c4m     = $signed({1'b0, c4}) - C4_BASE;
  assign c3s     = $signed({1'b0, c3});
  assign c6p     = {1'b0, c6} + C6_BASE;
  assign pc4_nxt = c4m * dt_r;
  assign pc3_nxt = c3s * dt_r;
  assign pt_nxt  = $signed({1'b0, c6p}) * dt_r;

  // stage 3: OFF, SENS, temperature
  logic signed [16:0] off_nxt, off_r;
  logic signed [18:0] sens_nxt, sens_r;
  logic signed [23:0] temp_nxt, temp_r;
  logic signed [16:0] d1m3_r;

  assign off_nxt  = $signed({3'b000, c2, 2'b00}) + 17'(pc4_r >>> OFF_SHIFT);
  assign sens_nxt = $signed({4'b0000, c1}) + 19'(pc3_r >>> SENS_SHIFT) + SENS_BASE;
  assign temp_nxt = 24'(pt_r) + TEMP_BASE;

  // stage 4: SENS * (D1 - 7168)
  logic signed [35:0] prod_nxt, prod_r;
  logic signed [16:0] off4_r;
  logic signed [23:0] temp4_r;

  assign prod_nxt = sens_r * d1m3_r;

  // stage 5: pressure
  logic signed [20:0] pres_nxt, pres_r;
  logic signed [23:0] temp5_r;

  assign pres_nxt = 21'(prod_r >>> X_SHIFT) - 21'(off4_r) + PRES_BASE;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wa_r <= '0;
      wb_r <= '0;
      wc_r <= '0;
      wd_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_CALIB_A: wa_r <= cfg_wdata;
        REG_CALIB_B: wb_r <= cfg_wdata;
        REG_CALIB_C: wc_r <= cfg_wdata;
        REG_CALIB_D: wd_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
      if (rdy5) v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      dt_r  <= dt_nxt;
      d1m_r <= d1m_nxt;
    end
    if (rdy2 && v1_r) begin
      pc4_r  <= pc4_nxt;
      pc3_r  <= pc3_nxt;
      pt_r   <= pt_nxt;
      d1m2_r <= d1m_r;
    end
    if (rdy3 && v2_r) begin
      off_r  <= off_nxt;
      sens_r <= sens_nxt;
      temp_r <= temp_nxt;
      d1m3_r <= d1m2_r;
    end
    if (rdy4 && v3_r) begin
      prod_r  <= prod_nxt;
      off4_r  <= off_r;
      temp4_r <= temp_r;
    end
    if (rdy5 && v4_r) begin
      pres_r  <= pres_nxt;
      temp5_r <= temp4_r;
    end
  end

  assign out_valid           = v5_r;
  assign out_pressure_q5     = pres_r;
  assign out_temperature_q10 = temp5_r;

  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall && v1_r && v4_r))
    else $error("input stalled while pipeline has room");

  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && $past(in_valid && !in_stall)) |-> v1_r)
    else $error("accepted request lost at stage 1");

  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && $past(out_valid && !out_stall && !v4_r)) |-> !out_valid)
    else $error("result repeated after delivery");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && $past(out_valid && out_stall)) |-> (out_valid && $stable(pres_r)))
    else $error("stalled result changed");

endmodule
